### hdl/rmd_pkg.sv
// ---------------------------------------------------------------------------
// rmd_pkg
// Constants, tables and step functions of the digest core.
// ---------------------------------------------------------------------------
package rmd_pkg;

  localparam int unsigned NumSteps = 80;

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  typedef struct packed {
    logic load_byte;
    logic [5:0] pos;
    logic [7:0] byte_val;
    logic clear_from;
    logic write_len;
    logic clear_block;
    logic start_round;
    logic step;
    logic [6:0] step_idx;
    logic finish;
    logic reset_state;
    logic add_count;
  } cmd_t;

  function automatic logic [3:0] sel_l(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,
          4'd15,
          4'd7,4'd4,4'd13,4'd1,4'd10,4'd6,4'd15,4'd3,4'd12,4'd0,4'd9,4'd5,4'd2,4'd14,4'd11,
          4'd8,
          4'd3,4'd10,4'd14,4'd4,4'd9,4'd15,4'd8,4'd1,4'd2,4'd7,4'd0,4'd6,4'd13,4'd11,4'd5,
          4'd12,
          4'd1,4'd9,4'd11,4'd10,4'd0,4'd8,4'd12,4'd4,4'd13,4'd3,4'd7,4'd15,4'd14,4'd5,4'd6,
          4'd2,
          4'd4,4'd0,4'd5,4'd9,4'd7,4'd12,4'd2,4'd10,4'd14,4'd1,4'd3,4'd8,4'd11,4'd6,4'd15,
          4'd13};
    return t[j];
  endfunction

  function automatic logic [3:0] sel_r(input logic [6:0] j);
    logic [3:0] t [80];
    t = '{4'd5,4'd14,4'd7,4'd0,4'd9,4'd2,4'd11,4'd4,4'd13,4'd6,4'd15,4'd8,4'd1,4'd10,4'd3,
          4'd12,
          4'd6,4'd11,4'd3,4'd7,4'd0,4'd13,4'd5,4'd10,4'd14,4'd15,4'd8,4'd12,4'd4,4'd9,4'd1,
          4'd2,
          4'd15,4'd5,4'd1,4'd3,4'd7,4'd14,4'd6,4'd9,4'd11,4'd8,4'd12,4'd2,4'd10,4'd0,4'd4,
          4'd13,
          4'd8,4'd6,4'd4,4'd1,4'd3,4'd11,4'd15,4'd0,4'd5,4'd12,4'd2,4'd13,4'd9,4'd7,4'd10,
          4'd14,
          4'd12,4'd15,4'd10,4'd4,4'd1,4'd5,4'd8,4'd7,4'd6,4'd2,4'd13,4'd14,4'd0,4'd3,4'd9,
          4'd11};
    return t[j];
  endfunction

  function automatic logic [4:0] rot_l(input logic [6:0] j);
    logic [4:0] t [80];
    t = '{5'd11,5'd14,5'd15,5'd12,5'd5,5'd8,5'd7,5'd9,5'd11,5'd13,5'd14,5'd15,5'd6,5'd7,
          5'd9,5'd8,
          5'd7,5'd6,5'd8,5'd13,5'd11,5'd9,5'd7,5'd15,5'd7,5'd12,5'd15,5'd9,5'd11,5'd7,
          5'd13,5'd12,
          5'd11,5'd13,5'd6,5'd7,5'd14,5'd9,5'd13,5'd15,5'd14,5'd8,5'd13,5'd6,5'd5,5'd12,
          5'd7,5'd5,
          5'd11,5'd12,5'd14,5'd15,5'd14,5'd15,5'd9,5'd8,5'd9,5'd14,5'd5,5'd6,5'd8,5'd6,
          5'd5,5'd12,
          5'd9,5'd15,5'd5,5'd11,5'd6,5'd8,5'd13,5'd12,5'd5,5'd12,5'd13,5'd14,5'd11,5'd8,
          5'd5,5'd6};
    return t[j];
  endfunction

  function automatic logic [4:0] rot_r(input logic [6:0] j);
    logic [4:0] t [80];
    t = '{5'd8,5'd9,5'd9,5'd11,5'd13,5'd15,5'd15,5'd5,5'd7,5'd7,5'd8,5'd11,5'd14,5'd14,
          5'd12,5'd6,
          5'd9,5'd13,5'd15,5'd7,5'd12,5'd8,5'd9,5'd11,5'd7,5'd7,5'd12,5'd7,5'd6,5'd15,
          5'd13,5'd11,
          5'd9,5'd7,5'd15,5'd11,5'd8,5'd6,5'd6,5'd14,5'd12,5'd13,5'd5,5'd14,5'd13,5'd13,
          5'd7,5'd5,
          5'd15,5'd5,5'd8,5'd11,5'd14,5'd14,5'd6,5'd14,5'd6,5'd9,5'd12,5'd9,5'd12,5'd5,
          5'd15,5'd8,
          5'd8,5'd5,5'd12,5'd9,5'd12,5'd5,5'd14,5'd6,5'd8,5'd13,5'd6,5'd5,5'd15,5'd13,
          5'd11,5'd11};
    return t[j];
  endfunction

  function automatic logic [31:0] add_l(input logic [2:0] rd);
    case (rd)
      3'd0: return 32'h00000000;
      3'd1: return 32'h5A827999;
      3'd2: return 32'h6ED9EBA1;
      3'd3: return 32'h8F1BBCDC;
      default: return 32'hA953FD4E;
    endcase
  endfunction

  function automatic logic [31:0] add_r(input logic [2:0] rd);
    case (rd)
      3'd0: return 32'h50A28BE6;
      3'd1: return 32'h5C4DD124;
      3'd2: return 32'h6D703EF3;
      3'd3: return 32'h7A6D76E9;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic [31:0] mix(input logic [2:0] rd, input logic [31:0] x,
                                      input logic [31:0] y, input logic [31:0] z);
    case (rd)
      3'd0: return x ^ y ^ z;
      3'd1: return (x & y) | (~x & z);
      3'd2: return (x | ~y) ^ z;
      3'd3: return (x & z) | (y & ~z);
      default: return x ^ (y | ~z);
    endcase
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} << n;
    return d[63:32];
  endfunction

endpackage

### hdl/rmd_datapath.sv
// ---------------------------------------------------------------------------
// rmd_datapath
// Block buffer, bit count, two working lines and chaining words.
// ---------------------------------------------------------------------------
module rmd_datapath import rmd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output logic [63:0]  bit_count_o,
  output logic [159:0] chain_o
);

  logic [31:0] blk_q [16];
  logic [31:0] l_q [5];
  logic [31:0] r_q [5];
  logic [31:0] h_q [5];
  logic [63:0] cnt_q;

  logic [2:0]  rd_l, rd_r;
  logic [31:0] tl, tr;

  always_comb begin
    rd_l = 3'(cmd_i.step_idx >> 4);
    rd_r = 3'd4 - rd_l;
    tl = rotl(l_q[0] + mix(rd_l, l_q[1], l_q[2], l_q[3]) + blk_q[sel_l(cmd_i.step_idx)]
              + add_l(rd_l), rot_l(cmd_i.step_idx)) + l_q[4];
    tr = rotl(r_q[0] + mix(rd_r, r_q[1], r_q[2], r_q[3]) + blk_q[sel_r(cmd_i.step_idx)]
              + add_r(rd_l), rot_r(cmd_i.step_idx)) + r_q[4];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      if (cmd_i.clear_block) begin
        blk_q[i] <= '0;
      end else if (cmd_i.clear_from) begin
        for (int b = 0; b < 4; b++) begin
          if (6'(i * 4 + b) == cmd_i.pos) begin
            blk_q[i][b*8 +: 8] <= 8'h80;
          end else if (6'(i * 4 + b) > cmd_i.pos) begin
            blk_q[i][b*8 +: 8] <= 8'h00;
          end
        end
      end else if (cmd_i.load_byte && 4'(i) == cmd_i.pos[5:2]) begin
        blk_q[i][cmd_i.pos[1:0]*8 +: 8] <= cmd_i.byte_val;
      end
    end
    if (cmd_i.write_len) begin
      blk_q[14] <= cnt_q[31:0];
      blk_q[15] <= cnt_q[63:32];
    end
    if (cmd_i.start_round) begin
      for (int i = 0; i < 5; i++) begin
        l_q[i] <= h_q[i];
        r_q[i] <= h_q[i];
      end
    end else if (cmd_i.step) begin
      l_q[0] <= l_q[4];
      l_q[4] <= l_q[3];
      l_q[3] <= rotl(l_q[2], 5'd10);
      l_q[2] <= l_q[1];
      l_q[1] <= tl;
      r_q[0] <= r_q[4];
      r_q[4] <= r_q[3];
      r_q[3] <= rotl(r_q[2], 5'd10);
      r_q[2] <= r_q[1];
      r_q[1] <= tr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q[0] <= Iv0; h_q[1] <= Iv1; h_q[2] <= Iv2; h_q[3] <= Iv3; h_q[4] <= Iv4;
      cnt_q  <= '0;
    end else begin
      if (cmd_i.add_count) begin
        cnt_q <= cnt_q + 64'd8;
      end
      if (cmd_i.reset_state) begin
        h_q[0] <= Iv0; h_q[1] <= Iv1; h_q[2] <= Iv2; h_q[3] <= Iv3; h_q[4] <= Iv4;
        cnt_q  <= '0;
      end else if (cmd_i.finish) begin
        h_q[0] <= h_q[1] + l_q[2] + r_q[3];
        h_q[1] <= h_q[2] + l_q[3] + r_q[4];
        h_q[2] <= h_q[3] + l_q[4] + r_q[0];
        h_q[3] <= h_q[4] + l_q[0] + r_q[1];
        h_q[4] <= h_q[0] + l_q[1] + r_q[2];
      end
    end
  end

  assign bit_count_o = cnt_q;
  assign chain_o = {h_q[4], h_q[3], h_q[2], h_q[1], h_q[0]};

endmodule

### hdl/rmd_control.sv
// ---------------------------------------------------------------------------
// rmd_control
// Sequencer: byte intake, padding, compression steps and digest output.
// ---------------------------------------------------------------------------
module rmd_control import rmd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   msg_byte_i,
  input  logic         byte_present_i,
  input  logic         final_item_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  digest_word_o,
  output logic [2:0]   word_number_o,
  output logic         last_word_o,
  input  logic [63:0]  bit_count_i,
  input  logic [159:0] chain_i,
  output cmd_t         cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StInit = 3'd2;
  localparam logic [2:0] StStep = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [6:0] idx_q, idx_d;
  logic       fin_q, fin_d;
  logic       last_q, last_d;
  logic [2:0] wn_q, wn_d;
  logic [5:0] pos;
  logic [31:0] w;
  logic       acc;
  // second pass of padding after an overflow block clears the whole block
  logic       ovf_q;

  assign pos = bit_count_i[8:3];
  assign in_stall_o = (state_q != StIdle);
  assign acc = in_valid_i && (state_q == StIdle);
  assign w = chain_i[wn_q*32 +: 32];

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    fin_d = fin_q;
    last_d = last_q;
    wn_d = wn_q;
    cmd_o = '0;
    cmd_o.pos = pos;
    cmd_o.byte_val = msg_byte_i;
    cmd_o.step_idx = idx_q;
    case (state_q)
      StIdle: begin
        if (acc) begin
          fin_d = final_item_i;
          if (byte_present_i) begin
            cmd_o.load_byte = 1'b1;
            cmd_o.add_count = 1'b1;
            if (pos == 6'd63) begin
              last_d = 1'b0;
              state_d = StInit;
            end else if (final_item_i) begin
              state_d = StPad;
            end
          end else if (final_item_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        if (ovf_q) begin
          cmd_o.clear_block = 1'b1;
        end else begin
          cmd_o.clear_from = 1'b1;
        end
        last_d = (pos < 6'd56);
        state_d = StInit;
      end
      StInit: begin
        if (last_q) begin
          cmd_o.write_len = 1'b1;
        end
        cmd_o.start_round = 1'b1;
        idx_d = '0;
        state_d = StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        idx_d = idx_q + 7'd1;
        if (idx_q == 7'(NumSteps - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        cmd_o.finish = 1'b1;
        if (last_q) begin
          wn_d = '0;
          state_d = StOut;
        end else if (fin_q) begin
          state_d = StPad;
          // block full at final byte, or no room left for the length: padding block follows
        end else begin
          state_d = StIdle;
        end
        if (fin_q && !last_q) begin
          state_d = StPad;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          wn_d = wn_q + 3'd1;
          if (wn_q == 3'd4) begin
            cmd_o.reset_state = 1'b1;
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      fin_q <= 1'b0;
      last_q <= 1'b0;
      wn_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      fin_q <= fin_d;
      wn_q <= wn_d;
      if (state_q == StPad) begin
        last_q <= last_d || ovf_q;
        ovf_q <= !(last_d || ovf_q);
      end else begin
        last_q <= last_d;
      end
      if (state_q == StOut && state_d == StIdle) begin
        ovf_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = (state_q == StOut);
  assign digest_word_o = {w[7:0], w[15:8], w[23:16], w[31:24]};
  assign word_number_o = wn_q;
  assign last_word_o = (wn_q == 3'd4);

endmodule

### hdl/ripemd160_hash.sv
// ---------------------------------------------------------------------------
// ripemd160_hash
// RIPEMD-160 digest of a byte stream.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one beat per message byte;
// byte_present_i marks a data byte, final_item_i ends the message.
// A plain byte is taken without a stall. The 64th byte of a block starts a
// compression (load, 80 steps, feed-forward), during which in_stall_o is
// high. A final beat adds one or two compressions, each preceded by a
// padding step, then five digest beats on the output channel
// (out_valid_o / out_stall_i), word_number_o 0..4, last_word_o on word 4.
// While the receiver stalls the digest word holds and no input is taken.
// Reset restores the initial chaining values and a zero length; afterward
// the block is ready for a message.
// ---------------------------------------------------------------------------
module ripemd160_hash import rmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_present_i,
  input  logic        final_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_number_o,
  output logic        last_word_o
);

  cmd_t         cmd;
  logic [63:0]  bit_count;
  logic [159:0] chain;

  rmd_control u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .msg_byte_i, .byte_present_i,
    .final_item_i, .out_valid_o, .out_stall_i, .digest_word_o, .word_number_o,
    .last_word_o, .bit_count_i(bit_count), .chain_i(chain), .cmd_o(cmd)
  );

  rmd_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .bit_count_o(bit_count), .chain_o(chain)
  );

endmodule
